### design/ssp_pkg.sv
// ----------------------------------------------------------------------------
// ssp_pkg: shared types for the string period finder
// Control group sent to the comparison cells and the sequencer state type.
// ----------------------------------------------------------------------------
package ssp_pkg;

    localparam int PERIOD_W = 6;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_SCAN
    } ssp_state_t;

    typedef struct packed {
        logic take;        // a byte request is accepted this cycle
        logic last;        // that byte closes the string
        logic scan_shift;  // move the candidate bits one cell toward cell 0
    } ssp_cell_ctl_t;

endpackage

### design/ssp_cell.sv
// ----------------------------------------------------------------------------
// ssp_cell: one shift of the period search
// Holds the byte INDEX+1 places back, compares it with each new byte and
// keeps a sticky mismatch flag; on the final byte it latches a candidate bit.
// ----------------------------------------------------------------------------
module ssp_cell
    import ssp_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  ssp_cell_ctl_t       ctl,
    input  logic [7:0]          byte_in,
    input  logic [7:0]          prev_byte,
    input  logic                prev_filled,
    input  logic                scan_in,
    input  logic [CNT_W-1:0]    elig_count,
    input  logic                elig_ovf,
    output logic [7:0]          recent_byte,
    output logic                filled,
    output logic                scan_bit
);

    localparam int NEED = 2 * (INDEX + 1);

    logic [7:0] recent_reg;
    logic [7:0] recent_next;
    logic       filled_reg;
    logic       filled_next;
    logic       broken_reg;
    logic       broken_next;
    logic       scan_reg;
    logic       scan_next;
    logic       broken_upd;
    logic       eligible;

    assign broken_upd = broken_reg | (filled_reg && (recent_reg != byte_in));
    assign eligible   = elig_ovf || (elig_count >= CNT_W'(NEED));

    always_comb
    begin
        recent_next = recent_reg;
        filled_next = filled_reg;
        broken_next = broken_reg;
        scan_next   = scan_reg;
        if (ctl.take)
        begin
            recent_next = prev_byte;
            filled_next = ctl.last ? 1'b0 : prev_filled;
            broken_next = ctl.last ? 1'b0 : broken_upd;
            if (ctl.last)
            begin
                scan_next = eligible && !broken_upd;
            end
        end
        if (ctl.scan_shift)
        begin
            scan_next = scan_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
            broken_reg <= 1'b0;
            scan_reg   <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
            broken_reg <= broken_next;
            scan_reg   <= scan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        recent_reg <= recent_next;
    end

    assign recent_byte = recent_reg;
    assign filled      = filled_reg;
    assign scan_bit    = scan_reg;

endmodule

### design/ssp_ctrl.sv
// ----------------------------------------------------------------------------
// ssp_ctrl: length count, candidate scan and result register
// Counts bytes, drives the cell row, walks the candidate bits after the
// final byte and holds the result until it is taken.
// ----------------------------------------------------------------------------
module ssp_ctrl
    import ssp_pkg::*;
#(
    parameter int MAX_LEN = 64,
    parameter int NSHIFT  = 32,
    parameter int CNT_W   = 7,
    parameter int IDX_W   = 6
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                last_byte,
    input  logic                out_stall,
    output logic                out_valid,
    output logic [PERIOD_W-1:0] period,
    output logic                too_long,
    input  logic                scan_head,
    output ssp_cell_ctl_t       cell_ctl,
    output logic [CNT_W-1:0]    elig_count,
    output logic                elig_ovf
);

    ssp_state_t          state_reg;
    ssp_state_t          state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                tl_reg;
    logic                tl_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [PERIOD_W-1:0] period_reg;
    logic [PERIOD_W-1:0] period_next;
    logic                too_long_reg;
    logic                too_long_next;

    logic in_take;
    logic full;
    logic out_free;
    logic scan_done;
    logic load_result;
    logic shift_en;

    assign full       = (count_reg >= CNT_W'(MAX_LEN));
    assign elig_count = full ? count_reg : count_reg + 1'b1;
    assign elig_ovf   = ovf_reg | full;
    assign out_free   = !out_valid_reg || !out_stall;
    assign scan_done  = scan_head || (idx_reg == IDX_W'(NSHIFT));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_take && last_byte)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done && out_free)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall    = 1'b0;
        load_result = 1'b0;
        shift_en    = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                in_stall = 1'b0;
            end
            ST_SCAN:
            begin
                in_stall    = 1'b1;
                load_result = scan_done && out_free;
                shift_en    = !scan_done;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign in_take             = in_valid && !in_stall;
    assign cell_ctl.take       = in_take;
    assign cell_ctl.last       = last_byte;
    assign cell_ctl.scan_shift = shift_en;

    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        idx_next       = idx_reg;
        tl_next        = tl_reg;
        out_valid_next = out_valid_reg && out_stall;
        period_next    = period_reg;
        too_long_next  = too_long_reg;
        if (in_take)
        begin
            if (last_byte)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                tl_next    = elig_ovf;
                idx_next   = IDX_W'(1);
            end
            else
            begin
                count_next = elig_count;
                ovf_next   = elig_ovf;
            end
        end
        if (shift_en)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (load_result)
        begin
            out_valid_next = 1'b1;
            period_next    = scan_head ? PERIOD_W'(idx_reg) : '0;
            too_long_next  = tl_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= IDX_W'(1);
            tl_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            idx_reg       <= idx_next;
            tl_reg        <= tl_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg   <= period_next;
        too_long_reg <= too_long_next;
    end

    assign out_valid = out_valid_reg;
    assign period    = period_reg;
    assign too_long  = too_long_reg;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("byte count beyond maximum length");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CNT_W'(MAX_LEN)))
        else $error("overflow flag set with count below maximum");

    a_scan_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg >= IDX_W'(1) && idx_reg <= IDX_W'(NSHIFT)))
        else $error("scan index out of range");

    a_last_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && last_byte) |=> (state_reg == ST_SCAN && count_reg == '0))
        else $error("final byte did not start the scan");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SCAN))
        else $error("result appeared outside a scan");
`endif

endmodule

### design/smallest_string_period.sv
// ----------------------------------------------------------------------------
// smallest_string_period: smallest repeat period of a byte string
// Row of MAX_LEN/2 compare cells plus a sequencer that reports the period.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while a string is being collected; each one
// is compared in that cycle against the bytes 1 to MAX_LEN/2 places back,
// one cell of the row per shift. After the final byte the input stalls while
// the row's candidate bits are shifted out one cell per cycle: the scan stops
// at the first set bit, the smallest period, else at the last cell, and the
// result then sits in an output register until taken (the next string may
// start while it waits). Periods above MAX_LEN/2 are not searched; a string
// longer than MAX_LEN sets too_long. Reset clears flags but not bytes or result.
module smallest_string_period
    import ssp_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          byte_value,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [PERIOD_W-1:0] period,
    output logic                too_long
);

    localparam int NSHIFT = MAX_LEN / 2;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int IDX_W  = $clog2(NSHIFT + 1);

    ssp_cell_ctl_t    cell_ctl;
    logic [CNT_W-1:0] elig_count;
    logic             elig_ovf;
    logic [7:0]       recent_byte [NSHIFT];
    logic             filled      [NSHIFT];
    logic             scan_bit    [NSHIFT];

    ssp_ctrl #(
        .MAX_LEN (MAX_LEN),
        .NSHIFT  (NSHIFT),
        .CNT_W   (CNT_W),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_byte  (last_byte),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .period     (period),
        .too_long   (too_long),
        .scan_head  (scan_bit[0]),
        .cell_ctl   (cell_ctl),
        .elig_count (elig_count),
        .elig_ovf   (elig_ovf)
    );

    for (genvar k = 0; k < NSHIFT; k++)
    begin : g_cell
        logic [7:0] prev_byte;
        logic       prev_filled;
        logic       scan_in;

        if (k == 0)
        begin : g_head
            assign prev_byte   = byte_value;
            assign prev_filled = 1'b1;
        end
        else
        begin : g_body
            assign prev_byte   = recent_byte[k-1];
            assign prev_filled = filled[k-1];
        end

        if (k == NSHIFT - 1)
        begin : g_tail
            assign scan_in = 1'b0;
        end
        else
        begin : g_mid
            assign scan_in = scan_bit[k+1];
        end

        ssp_cell #(
            .INDEX (k),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (cell_ctl),
            .byte_in     (byte_value),
            .prev_byte   (prev_byte),
            .prev_filled (prev_filled),
            .scan_in     (scan_in),
            .elig_count  (elig_count),
            .elig_ovf    (elig_ovf),
            .recent_byte (recent_byte[k]),
            .filled      (filled[k]),
            .scan_bit    (scan_bit[k])
        );
    end

endmodule
